[rtl/iedf_pkg.sv]
// Shared types, code tables and constants for the input event message deframer.
package iedf_pkg;

    localparam int NUM_CODES = 14;

    localparam logic [3:0] KIND_HELLO = 4'd0;
    localparam logic [3:0] KIND_BYE   = 4'd10;
    localparam logic [3:0] KIND_NONE  = 4'd15;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BYE     = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;

    localparam logic [1:0] SRC_ARG0 = 2'd0;
    localparam logic [1:0] SRC_ARG1 = 2'd1;
    localparam logic [1:0] SRC_ARG2 = 2'd2;
    localparam logic [1:0] SRC_ZERO = 2'd3;

    localparam logic [3:0] BYE_INDEX = 4'd5;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CODE,
        PH_ARGS,
        PH_SKIP,
        PH_DISCARD
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_last;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic [1:0]  error_flag;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_t;

    // Code text, padded with zero past each code's length.
    localparam logic [7:0] CODE_TEXT [NUM_CODES][8] = '{
        '{8'h53, 8'h79, 8'h6E, 8'h65, 8'h72, 8'h67, 8'h79, 8'h00},
        '{8'h51, 8'h49, 8'h4E, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h41, 8'h4C, 8'h56, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h49, 8'h4E, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h4F, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h42, 8'h59, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h4D, 8'h4D, 8'h56, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h4D, 8'h52, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h4D, 8'h44, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h4D, 8'h55, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h4B, 8'h44, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h4B, 8'h55, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h4B, 8'h52, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h43, 8'h4C, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] CODE_LEN [NUM_CODES] = '{
        3'd7, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    localparam logic [3:0] CODE_KIND [NUM_CODES] = '{
        4'd0, 4'd1, 4'd2, 4'd3, KIND_NONE, KIND_BYE, 4'd3,
        4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, KIND_NONE
    };

    localparam logic [2:0] CODE_NARGS [NUM_CODES] = '{
        3'd2, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd2,
        3'd2, 3'd1, 3'd1, 3'd3, 3'd3, 3'd4, 3'd0
    };

    localparam logic [2:0] CODE_ARGW [NUM_CODES][4] = '{
        '{3'd2, 3'd2, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd2, 3'd2, 3'd4, 3'd2},
        '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd2, 3'd2, 3'd0, 3'd0}, '{3'd2, 3'd2, 3'd0, 3'd0},
        '{3'd1, 3'd0, 3'd0, 3'd0}, '{3'd1, 3'd0, 3'd0, 3'd0},
        '{3'd2, 3'd2, 3'd2, 3'd0}, '{3'd2, 3'd2, 3'd2, 3'd0},
        '{3'd2, 3'd2, 3'd2, 3'd2}, '{3'd0, 3'd0, 3'd0, 3'd0}
    };

    localparam logic [1:0] CODE_FIRST [NUM_CODES] = '{
        SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ARG0, SRC_ZERO, SRC_ZERO, SRC_ARG0,
        SRC_ARG0, SRC_ARG0, SRC_ARG0, SRC_ARG2, SRC_ARG2, SRC_ARG2, SRC_ZERO
    };

    localparam logic [1:0] CODE_SECOND [NUM_CODES] = '{
        SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ARG1, SRC_ZERO, SRC_ZERO, SRC_ARG1,
        SRC_ARG1, SRC_ZERO, SRC_ZERO, SRC_ARG1, SRC_ARG1, SRC_ARG1, SRC_ZERO
    };

endpackage

[rtl/iedf_in_stage.sv]
// Input register: holds one received item for the parser.
module iedf_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  iedf_pkg::in_item_t s_item,
    input  logic              step,
    output logic              item_valid,
    output iedf_pkg::in_item_t item
);
    import iedf_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Refill when empty or when the held item is consumed this cycle.
    assign s_ready    = !valid_reg || step;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[rtl/iedf_parser.sv]
// Message parser: header, code match and argument collection, one byte per step.
module iedf_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  iedf_pkg::in_item_t in_item,
    output iedf_pkg::res_t     res
);
    import iedf_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [2:0]           pos_reg, pos_next;
    logic [31:0]          left_reg, left_next;
    logic [23:0]          len_reg, len_next;
    logic [NUM_CODES-1:0] cand_reg, cand_next;
    logic                 mvld_reg, mvld_next;
    logic [3:0]           code_reg, code_next;
    logic [2:0]           aidx_reg, aidx_next;
    logic [7:0]           alast_reg, alast_next;
    logic [15:0]          saved_reg [3];
    logic [15:0]          saved_next [3];

    logic [7:0]           b;
    logic                 last;
    logic [31:0]          hdr_len;
    logic                 hdr_done;
    logic [2:0]           pos_inc;
    logic [NUM_CODES-1:0] keep;
    logic [NUM_CODES-1:0] hit;
    logic                 match_any;
    logic [3:0]           match_idx;
    logic [1:0]           a;
    logic                 arg_done;
    logic [2:0]           aidx_inc;
    logic                 args_full;
    logic                 in_body;
    logic                 body_end;
    logic                 emit;
    logic                 bye;
    logic                 overrun;
    logic                 restart;

    function automatic logic [15:0] pick(input logic [1:0] src, input logic [15:0] s0,
                                         input logic [15:0] s1, input logic [15:0] s2);
        logic [15:0] v;
        unique case (src)
            SRC_ARG0: v = s0;
            SRC_ARG1: v = s1;
            SRC_ARG2: v = s2;
            default:  v = 16'd0;
        endcase
        return v;
    endfunction

    always_comb begin
        b        = in_item.rx_byte;
        last     = in_item.chunk_last;
        hdr_len  = {len_reg, b};
        hdr_done = (pos_reg == 3'd3);
        pos_inc  = pos_reg + 3'd1;
        for (int i = 0; i < NUM_CODES; i++) begin
            keep[i] = cand_reg[i] && (pos_reg < CODE_LEN[i]) && (CODE_TEXT[i][pos_reg] == b);
            hit[i]  = keep[i] && (CODE_LEN[i] == pos_inc);
        end
        match_any = |hit;
        // Lowest code index wins.
        match_idx = 4'd0;
        for (int i = NUM_CODES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                match_idx = 4'(i);
            end
        end
        a         = aidx_reg[1:0];
        arg_done  = (pos_inc >= CODE_ARGW[code_reg][a]);
        aidx_inc  = aidx_reg + 3'd1;
        args_full = (aidx_inc >= CODE_NARGS[code_reg]);
        in_body   = (phase_reg == PH_CODE) || (phase_reg == PH_ARGS) || (phase_reg == PH_SKIP);
        body_end  = in_body && (left_reg == 32'd1);
    end

    // Datapath and result.
    always_comb begin
        pos_next   = pos_reg;
        left_next  = left_reg;
        len_next   = len_reg;
        cand_next  = cand_reg;
        mvld_next  = mvld_reg;
        code_next  = code_reg;
        aidx_next  = aidx_reg;
        alast_next = alast_reg;
        for (int k = 0; k < 3; k++) begin
            saved_next[k] = saved_reg[k];
        end

        unique case (phase_reg)
            PH_HEADER: begin
                len_next = hdr_len[23:0];
                pos_next = pos_inc;
                if (hdr_done) begin
                    left_next  = hdr_len;
                    len_next   = 24'd0;
                    pos_next   = 3'd0;
                    mvld_next  = 1'b0;
                    aidx_next  = 3'd0;
                    alast_next = 8'd0;
                    cand_next  = '1;
                end
            end
            PH_CODE: begin
                left_next = left_reg - 32'd1;
                cand_next = keep;
                pos_next  = pos_inc;
                if (match_any) begin
                    mvld_next = 1'b1;
                    code_next = match_idx;
                    cand_next = '0;
                    pos_next  = 3'd0;
                end
            end
            PH_ARGS: begin
                left_next  = left_reg - 32'd1;
                alast_next = b;
                pos_next   = pos_inc;
                if (arg_done) begin
                    case (a)
                        2'd0:    saved_next[0] = {alast_reg, b};
                        2'd1:    saved_next[1] = {alast_reg, b};
                        2'd2:    saved_next[2] = {alast_reg, b};
                        default: ;
                    endcase
                    aidx_next  = aidx_inc;
                    pos_next   = 3'd0;
                    alast_next = 8'd0;
                end
            end
            PH_SKIP: begin
                left_next = left_reg - 32'd1;
            end
            PH_DISCARD: ;
            default: ;
        endcase

        emit = body_end && mvld_next && (aidx_next >= CODE_NARGS[code_next]) &&
               (CODE_KIND[code_next] != KIND_NONE);
        bye  = emit && (code_next == BYE_INDEX);
        overrun = last && (((phase_reg == PH_HEADER) && !(hdr_done && (hdr_len == 32'd0))) ||
                           (in_body && !body_end));

        res.valid = emit || overrun;
        if (overrun) begin
            res.item = '{event_kind: KIND_HELLO, first_value: 16'd0, second_value: 16'd0,
                         error_flag: ERR_OVERRUN};
        end else begin
            res.item.event_kind   = CODE_KIND[code_next];
            res.item.first_value  = pick(CODE_FIRST[code_next], saved_next[0],
                                         saved_next[1], saved_next[2]);
            res.item.second_value = pick(CODE_SECOND[code_next], saved_next[0],
                                         saved_next[1], saved_next[2]);
            res.item.error_flag   = bye ? ERR_BYE : ERR_NONE;
        end

        // Drop message state at a body end or chunk end.
        restart = body_end || last;
        if (restart) begin
            pos_next   = 3'd0;
            left_next  = 32'd0;
            len_next   = 24'd0;
            cand_next  = '0;
            mvld_next  = 1'b0;
            code_next  = 4'd0;
            aidx_next  = 3'd0;
            alast_next = 8'd0;
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                if (hdr_done) begin
                    phase_next = (hdr_len == 32'd0) ? PH_HEADER : PH_CODE;
                end
            end
            PH_CODE: begin
                if (match_any) begin
                    phase_next = (CODE_NARGS[match_idx] != 3'd0) ? PH_ARGS : PH_SKIP;
                end else if (keep == '0) begin
                    phase_next = PH_SKIP;
                end
            end
            PH_ARGS: begin
                if (arg_done && args_full) begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP, PH_DISCARD: ;
            default: phase_next = PH_HEADER;
        endcase
        if (body_end) begin
            phase_next = (bye && !last) ? PH_DISCARD : PH_HEADER;
        end
        if (last) begin
            phase_next = PH_HEADER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 3'd0;
            left_reg  <= 32'd0;
            len_reg   <= 24'd0;
            cand_reg  <= '0;
            mvld_reg  <= 1'b0;
            code_reg  <= 4'd0;
            aidx_reg  <= 3'd0;
            alast_reg <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            len_reg   <= len_next;
            cand_reg  <= cand_next;
            mvld_reg  <= mvld_next;
            code_reg  <= code_next;
            aidx_reg  <= aidx_next;
            alast_reg <= alast_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            for (int k = 0; k < 3; k++) begin
                saved_reg[k] <= saved_next[k];
            end
        end
    end

endmodule

[rtl/iedf_out_stage.sv]
// Result register: holds one decoded item until the sink takes it.
module iedf_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  iedf_pkg::res_t      res,
    output logic                out_free,
    output logic                m_valid,
    input  logic                m_ready,
    output iedf_pkg::out_item_t m_item
);
    import iedf_pkg::*;

    logic      valid_reg;
    out_item_t item_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (step) begin
            valid_reg <= res.valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res.valid) begin
            item_reg <= res.item;
        end
    end

endmodule

[rtl/input_event_message_deframer.sv]
// Top level of the input event message deframer.
// Path: a byte held in the input register is parsed once the result register is free;
// its result, if any, is written to the result register and offered to the sink.
// Throughput: one byte per cycle unless a result held in the result register is stalled.
// Reset: synchronous active-low aresetn empties both registers and returns the parser
// to waiting for a length header.
module input_event_message_deframer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iedf_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output iedf_pkg::out_item_t m_item
);
    import iedf_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     out_free;
    logic     step;
    res_t     res;

    assign step = item_valid && out_free;

    iedf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .step       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    iedf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_item (item),
        .res     (res)
    );

    iedf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

[rtl/iedf_checker.sv]
// Port-level checks for the deframer, bound to the top level.
module iedf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input iedf_pkg::out_item_t m_item
);
    import iedf_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // Input backpressure only comes from a stalled result.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    a_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.error_flag == ERR_OVERRUN) |->
            (m_item.event_kind == KIND_HELLO) && (m_item.first_value == 16'd0) &&
            (m_item.second_value == 16'd0))
        else $error("overrun item carries data");

    a_bye: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_item.error_flag == ERR_BYE) || (m_item.event_kind == KIND_BYE)) |->
            (m_item.event_kind == KIND_BYE) && (m_item.error_flag == ERR_BYE) &&
            (m_item.first_value == 16'd0) && (m_item.second_value == 16'd0))
        else $error("malformed bye item");

endmodule

bind input_event_message_deframer iedf_checker u_checker (.*);
